### rtl/fm_chip_timer_status_unit_defines.svh
// Assertion macros shared by the timer and status unit.
`ifndef FM_CHIP_TIMER_STATUS_UNIT_DEFINES_SVH
`define FM_CHIP_TIMER_STATUS_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define FM_CTSU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("fm_ctsu: property violated");

// Condition must never be seen at a clock edge outside reset.
`define FM_CTSU_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("fm_ctsu: forbidden condition seen");

`else

`define FM_CTSU_ASSERT(lbl, clk, rst, prop)
`define FM_CTSU_NEVER(lbl, clk, rst, cond)

`endif

`endif

### rtl/fm_ctsu_pkg.sv
// Types and constants of the timer and status unit.
package fm_ctsu_pkg;

   localparam int CHIPS = 2;
   localparam int IRQ_W = 2;

   localparam int RELOAD_W   = 9;
   localparam int FAST_REM_W = 11;
   localparam int SLOW_REM_W = 13;

   localparam logic [RELOAD_W-1:0] RELOAD_FULL = 9'd256;

   // item kinds
   typedef enum logic [2:0] {
      FUNC_TICK      = 3'd0,
      FUNC_ADDR_WR   = 3'd1,
      FUNC_DATA_WR   = 3'd2,
      FUNC_STATUS_RD = 3'd3,
      FUNC_DATA_RD   = 3'd4
   } func_type;

   // register numbers held in the address latch
   localparam logic [7:0] REG_FAST_RELOAD = 8'h02;
   localparam logic [7:0] REG_SLOW_RELOAD = 8'h03;
   localparam logic [7:0] REG_CONTROL     = 8'h04;

   // control and status bits
   localparam logic [7:0] CTRL_CLEAR_ALL = 8'h80;
   localparam logic [7:0] CTRL_FAST_RUN  = 8'h01;
   localparam logic [7:0] CTRL_SLOW_RUN  = 8'h02;
   localparam logic [7:0] FLAG_IRQ       = 8'h80;
   localparam logic [7:0] FLAG_FAST      = 8'h40;
   localparam logic [7:0] FLAG_SLOW      = 8'h20;
   localparam logic [7:0] FLAG_MASKS     = 8'h60;
   localparam logic [7:0] FLAG_TIMERS    = 8'h7f;

   typedef struct packed {
      func_type    func;
      logic        chip_index;
      logic [7:0]  data;
   } item_type;

   typedef struct packed {
      logic        go;
      logic        sel;
      func_type    func;
      logic [7:0]  data;
   } chip_op_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        irq;
   } chip_res_type;

endpackage

### rtl/fm_ctsu_chip.sv
// Register file, timers and status flags of one chip.
`include "fm_chip_timer_status_unit_defines.svh"

module fm_ctsu_chip (
   input  logic                      clock,
   input  logic                      reset,
   input  fm_ctsu_pkg::chip_op_type  op,
   output fm_ctsu_pkg::chip_res_type res
);

   logic [7:0]                         latch_ff, latch_in;
   logic [7:0]                         status_ff, status_in;
   logic [7:0]                         ctrl_ff, ctrl_in;
   logic [fm_ctsu_pkg::RELOAD_W-1:0]   fast_reload_ff, fast_reload_in;
   logic [fm_ctsu_pkg::RELOAD_W-1:0]   slow_reload_ff, slow_reload_in;
   logic                               fast_run_ff, fast_run_in;
   logic                               slow_run_ff, slow_run_in;
   logic [fm_ctsu_pkg::FAST_REM_W-1:0] fast_rem_ff, fast_rem_in;
   logic [fm_ctsu_pkg::SLOW_REM_W-1:0] slow_rem_ff, slow_rem_in;
   logic [fm_ctsu_pkg::FAST_REM_W-1:0] fast_load;
   logic [fm_ctsu_pkg::SLOW_REM_W-1:0] slow_load;
   logic [7:0]                         status_cut;

   // four ticks per fast count, sixteen per slow count
   assign fast_load = {fast_reload_ff, 2'b00};
   assign slow_load = {slow_reload_ff, 4'b0000};

   always_comb begin
      latch_in       = latch_ff;
      status_in      = status_ff;
      ctrl_in        = ctrl_ff;
      fast_reload_in = fast_reload_ff;
      slow_reload_in = slow_reload_ff;
      fast_run_in    = fast_run_ff;
      slow_run_in    = slow_run_ff;
      fast_rem_in    = fast_rem_ff;
      slow_rem_in    = slow_rem_ff;
      status_cut     = status_ff & ~(op.data & fm_ctsu_pkg::FLAG_MASKS);

      if (op.go) begin
         unique case (op.func)
            fm_ctsu_pkg::FUNC_TICK: begin
               if (fast_run_ff) begin
                  if (fast_rem_ff <= 11'd1) begin
                     if ((ctrl_ff & fm_ctsu_pkg::FLAG_FAST) == 8'h00) begin
                        status_in = status_in | fm_ctsu_pkg::FLAG_IRQ
                                    | fm_ctsu_pkg::FLAG_FAST;
                     end
                     fast_rem_in = fast_load;
                  end else begin
                     fast_rem_in = fast_rem_ff - 11'd1;
                  end
               end
               if (slow_run_ff) begin
                  if (slow_rem_ff <= 13'd1) begin
                     if ((ctrl_ff & fm_ctsu_pkg::FLAG_SLOW) == 8'h00) begin
                        status_in = status_in | fm_ctsu_pkg::FLAG_IRQ
                                    | fm_ctsu_pkg::FLAG_SLOW;
                     end
                     slow_rem_in = slow_load;
                  end else begin
                     slow_rem_in = slow_rem_ff - 13'd1;
                  end
               end
            end
            fm_ctsu_pkg::FUNC_ADDR_WR: begin
               if (op.sel) begin
                  latch_in = op.data;
               end
            end
            fm_ctsu_pkg::FUNC_DATA_WR: begin
               if (op.sel) begin
                  unique case (latch_ff)
                     fm_ctsu_pkg::REG_FAST_RELOAD: begin
                        fast_reload_in = fm_ctsu_pkg::RELOAD_FULL - {1'b0, op.data};
                     end
                     fm_ctsu_pkg::REG_SLOW_RELOAD: begin
                        slow_reload_in = fm_ctsu_pkg::RELOAD_FULL - {1'b0, op.data};
                     end
                     fm_ctsu_pkg::REG_CONTROL: begin
                        if ((op.data & fm_ctsu_pkg::CTRL_CLEAR_ALL) != 8'h00) begin
                           status_in = 8'h00;
                        end else begin
                           ctrl_in = op.data;
                           if ((op.data & fm_ctsu_pkg::CTRL_FAST_RUN) != 8'h00) begin
                              if (!fast_run_ff) begin
                                 fast_run_in = 1'b1;
                                 fast_rem_in = fast_load;
                              end
                           end else begin
                              fast_run_in = 1'b0;
                           end
                           if ((op.data & fm_ctsu_pkg::CTRL_SLOW_RUN) != 8'h00) begin
                              if (!slow_run_ff) begin
                                 slow_run_in = 1'b1;
                                 slow_rem_in = slow_load;
                              end
                           end else begin
                              slow_run_in = 1'b0;
                           end
                           // drop the IRQ bit once no timer flag is left
                           if ((status_cut & fm_ctsu_pkg::FLAG_TIMERS) == 8'h00) begin
                              status_in = 8'h00;
                           end else begin
                              status_in = status_cut;
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff       <= 8'h00;
         status_ff      <= 8'h00;
         ctrl_ff        <= 8'h00;
         fast_reload_ff <= fm_ctsu_pkg::RELOAD_FULL;
         slow_reload_ff <= fm_ctsu_pkg::RELOAD_FULL;
         fast_run_ff    <= 1'b0;
         slow_run_ff    <= 1'b0;
         fast_rem_ff    <= '0;
         slow_rem_ff    <= '0;
      end else begin
         latch_ff       <= latch_in;
         status_ff      <= status_in;
         ctrl_ff        <= ctrl_in;
         fast_reload_ff <= fast_reload_in;
         slow_reload_ff <= slow_reload_in;
         fast_run_ff    <= fast_run_in;
         slow_run_ff    <= slow_run_in;
         fast_rem_ff    <= fast_rem_in;
         slow_rem_ff    <= slow_rem_in;
      end
   end

   always_comb begin
      res.read_data = 8'h00;
      if (op.sel && op.func == fm_ctsu_pkg::FUNC_STATUS_RD) begin
         res.read_data = status_ff & ~(ctrl_ff & fm_ctsu_pkg::FLAG_MASKS);
      end
      res.irq = status_in[7];
   end

   // a timer flag never stands without the IRQ bit
   `FM_CTSU_ASSERT(a_flag_needs_irq, clock, reset, (status_ff[6] || status_ff[5]) |-> status_ff[7])
   // the low status bits are never set
   `FM_CTSU_NEVER(a_low_status_clear, clock, reset, status_ff[4:0] != 5'd0)
   // a stopped fast timer keeps its count
   `FM_CTSU_ASSERT(a_fast_hold, clock, reset, (!fast_run_ff && !fast_run_in) |=> $stable(fast_rem_ff))

endmodule

### rtl/fm_chip_timer_status_unit.sv
// Top level of the timer and status unit: stream ports, pipeline and chips.
//
// Timer and status registers of CHIPS (two) FM sound chips behind one word
// stream. Each request word is a tick, an address-latch write, a data-port
// write, a status read or a data-port read; each gives exactly one response
// word holding the read data (masked status for a status read, zero
// otherwise) and the IRQ lines of chips 0 and 1 after the word took effect.
// Throughput is one word per clock while responses are taken; a word goes
// through the input register, then through the chip update logic into the
// response register. The input register takes a further word while a
// response waits, so the request side stalls only when both registers are
// full and the response side is held. Ticks step every running timer of
// every chip; all other words act on the chip chosen by chip_index.
`include "fm_chip_timer_status_unit_defines.svh"

module fm_chip_timer_status_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data
   input  logic [3:0]  req_tuser,   // [2:0] func, [3] chip_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [7:0] read_data, [9:8] irq_lines, [15:10] zero
);

   fm_ctsu_pkg::item_type     s1_item_ff;
   logic                      s1_valid_ff, s1_valid_in;
   logic                      out_valid_ff, out_valid_in;
   logic [7:0]                out_read_ff;
   logic [fm_ctsu_pkg::IRQ_W-1:0] out_irq_ff;
   logic                      advance;
   logic                      req_take;
   logic [7:0]                read_mux;
   logic [fm_ctsu_pkg::IRQ_W-1:0] irq_mux;
   fm_ctsu_pkg::chip_op_type  chip_op [fm_ctsu_pkg::CHIPS];
   fm_ctsu_pkg::chip_res_type chip_res [fm_ctsu_pkg::CHIPS];

   // move the held word into the response register when that is free
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.func       <= fm_ctsu_pkg::func_type'(req_tuser[2:0]);
         s1_item_ff.chip_index <= req_tuser[3];
         s1_item_ff.data       <= req_tdata;
      end
      if (advance) begin
         out_read_ff <= read_mux;
         out_irq_ff  <= irq_mux;
      end
   end

   // one chip per index; a chip sees the word only when it is addressed,
   // except for ticks, which every chip takes
   for (genvar k = 0; k < fm_ctsu_pkg::CHIPS; k++) begin : g_chip
      assign chip_op[k].go   = advance;
      assign chip_op[k].sel  = (int'(s1_item_ff.chip_index) == k);
      assign chip_op[k].func = s1_item_ff.func;
      assign chip_op[k].data = s1_item_ff.data;

      fm_ctsu_chip u_chip (
         .clock (clock),
         .reset (reset),
         .op    (chip_op[k]),
         .res   (chip_res[k])
      );
   end

   // only the addressed chip drives read data; report IRQ of chips 0 and 1
   always_comb begin
      read_mux = 8'h00;
      irq_mux  = '0;
      for (int k = 0; k < fm_ctsu_pkg::CHIPS; k++) begin
         read_mux = read_mux | chip_res[k].read_data;
         if (k < fm_ctsu_pkg::IRQ_W) begin
            irq_mux[k] = chip_res[k].irq;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_irq_ff, out_read_ff};

   // a full pipeline with a held response takes no new word
   `FM_CTSU_NEVER(a_no_overrun, clock, reset, req_take && s1_valid_ff && out_valid_ff && !rsp_tready)
   // a held word stays put while the response side stalls
   `FM_CTSU_ASSERT(a_s1_hold, clock, reset, (s1_valid_ff && out_valid_ff && !rsp_tready) |=> (s1_valid_ff && $stable(s1_item_ff)))

endmodule

### dv/tb_fm_chip_timer_status_unit.sv
// Self-checking testbench for the timer and status unit of the two FM chips.
`timescale 1ns / 1ps

module tb_fm_chip_timer_status_unit;

   // Spare item kinds: the block must treat them as a no-op returning zero
   localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;
   // First frequency register; writes through the data port must be dropped
   localparam logic [7:0] REG_FNUM_BASE    = 8'hA0;

   localparam int RANDOM_WORDS = 900;
   localparam int IDLE_LIMIT   = 2000;  // cycles with no word accepted on either side
   localparam int DRAIN_CYCLES = 10;    // margin after the last response is due, to catch strays

   typedef logic [fm_ctsu_pkg::SLOW_REM_W-1:0] count_type;
   typedef logic [fm_ctsu_pkg::FAST_REM_W-1:0] fast_count_type;

   typedef struct packed {
      logic [7:0]                   read_data;
      logic [fm_ctsu_pkg::IRQ_W-1:0] irq_lines;
   } rsp_word_type;

   // One stimulus row; the wanted response is only used where typed is set
   typedef struct packed {
      logic [2:0]                   func;
      logic                         chip;
      logic [7:0]                   data;
      bit                           typed;
      logic [7:0]                   want_rd;
      logic [fm_ctsu_pkg::IRQ_W-1:0] want_irq;
   } step_row_type;

   localparam int DIRECTED_ROWS = 26;
   localparam step_row_type STEP_TABLE [DIRECTED_ROWS] = '{
      // quiet block after reset: every read is zero, no IRQ
      '{fm_ctsu_pkg::FUNC_STATUS_RD, 1'b0, 8'h00, 1'b1, 8'h00, 2'b00},
      '{fm_ctsu_pkg::FUNC_STATUS_RD, 1'b1, 8'hff, 1'b1, 8'h00, 2'b00},
      '{fm_ctsu_pkg::FUNC_DATA_RD,   1'b1, 8'hff, 1'b1, 8'h00, 2'b00},
      '{FUNC_SPARE_FIRST,            1'b0, 8'hff, 1'b1, 8'h00, 2'b00},
      '{FUNC_SPARE_LAST,             1'b1, 8'h00, 1'b1, 8'h00, 2'b00},
      '{fm_ctsu_pkg::FUNC_TICK,      1'b1, 8'hff, 1'b1, 8'h00, 2'b00},
      // data write with the latch still at zero: ignored
      '{fm_ctsu_pkg::FUNC_DATA_WR,   1'b0, 8'hff, 1'b1, 8'h00, 2'b00},
      // shortest fast reload, then start the fast timer unmasked
      '{fm_ctsu_pkg::FUNC_ADDR_WR, 1'b0, fm_ctsu_pkg::REG_FAST_RELOAD, 1'b0, 8'h00, 2'b00},
      '{fm_ctsu_pkg::FUNC_DATA_WR, 1'b0, 8'hff,                        1'b0, 8'h00, 2'b00},
      '{fm_ctsu_pkg::FUNC_ADDR_WR, 1'b0, fm_ctsu_pkg::REG_CONTROL,     1'b0, 8'h00, 2'b00},
      '{fm_ctsu_pkg::FUNC_DATA_WR, 1'b0, fm_ctsu_pkg::CTRL_FAST_RUN,   1'b0, 8'h00, 2'b00},
      '{fm_ctsu_pkg::FUNC_TICK,    1'b0, 8'h00,                        1'b0, 8'h00, 2'b00},
      '{fm_ctsu_pkg::FUNC_TICK,    1'b1, 8'h00,                        1'b0, 8'h00, 2'b00},
      // restart while running: fast count must stay, slow starts from 256 * 16
      '{fm_ctsu_pkg::FUNC_DATA_WR, 1'b0,
        fm_ctsu_pkg::CTRL_FAST_RUN | fm_ctsu_pkg::CTRL_SLOW_RUN,        1'b0, 8'h00, 2'b00},
      '{fm_ctsu_pkg::FUNC_TICK,      1'b0, 8'h00,                      1'b0, 8'h00, 2'b00},
      '{fm_ctsu_pkg::FUNC_TICK,      1'b0, 8'h00,                      1'b0, 8'h00, 2'b00},
      '{fm_ctsu_pkg::FUNC_STATUS_RD, 1'b0, 8'h00,                      1'b0, 8'h00, 2'b00},
      // frequency register write has no effect
      '{fm_ctsu_pkg::FUNC_ADDR_WR, 1'b0, REG_FNUM_BASE,                1'b0, 8'h00, 2'b00},
      '{fm_ctsu_pkg::FUNC_DATA_WR, 1'b0, 8'h55,                        1'b0, 8'h00, 2'b00},
      // mask the fast flag: clears it and drops the IRQ bit
      '{fm_ctsu_pkg::FUNC_ADDR_WR, 1'b0, fm_ctsu_pkg::REG_CONTROL,     1'b0, 8'h00, 2'b00},
      '{fm_ctsu_pkg::FUNC_DATA_WR, 1'b0,
        fm_ctsu_pkg::FLAG_FAST | fm_ctsu_pkg::CTRL_FAST_RUN,            1'b0, 8'h00, 2'b00},
      '{fm_ctsu_pkg::FUNC_STATUS_RD, 1'b0, 8'h00,                      1'b0, 8'h00, 2'b00},
      // longest slow reload on the second chip, then clear all status there
      '{fm_ctsu_pkg::FUNC_ADDR_WR, 1'b1, fm_ctsu_pkg::REG_SLOW_RELOAD, 1'b0, 8'h00, 2'b00},
      '{fm_ctsu_pkg::FUNC_DATA_WR, 1'b1, 8'h00,                        1'b0, 8'h00, 2'b00},
      '{fm_ctsu_pkg::FUNC_ADDR_WR, 1'b1, fm_ctsu_pkg::REG_CONTROL,     1'b0, 8'h00, 2'b00},
      '{fm_ctsu_pkg::FUNC_DATA_WR, 1'b1, fm_ctsu_pkg::CTRL_CLEAR_ALL,  1'b0, 8'h00, 2'b00}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] data
   logic [3:0]  req_tuser  = '0;   // [2:0] func, [3] chip_index
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [7:0] read_data, [9:8] irq_lines, [15:10] zero

   fm_chip_timer_status_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the per-chip timer and status state
   logic [7:0]                         latch_m      [fm_ctsu_pkg::CHIPS];
   logic [7:0]                         status_m     [fm_ctsu_pkg::CHIPS];
   logic [7:0]                         control_m    [fm_ctsu_pkg::CHIPS];
   logic [fm_ctsu_pkg::RELOAD_W-1:0]   fast_reload_m[fm_ctsu_pkg::CHIPS];
   logic [fm_ctsu_pkg::RELOAD_W-1:0]   slow_reload_m[fm_ctsu_pkg::CHIPS];
   logic                               fast_run_m   [fm_ctsu_pkg::CHIPS];
   logic                               slow_run_m   [fm_ctsu_pkg::CHIPS];
   fast_count_type                     fast_left_m  [fm_ctsu_pkg::CHIPS];
   count_type                          slow_left_m  [fm_ctsu_pkg::CHIPS];

   rsp_word_type status_words_due[$];
   int           fault_count = 0;
   int           words_sent  = 0;
   int           cycle_no    = 0;
   int           idle_cycles = 0;
   int           ready_hold  = 0;

   task automatic flag_fault(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fault_count++;
   endtask

   // Count one timer step down; on expiry reload and, if unmasked, raise the flags
   function automatic count_type run_down(input int c, input count_type left,
                                          input count_type span, input logic [7:0] flag);
      if (left <= count_type'(1)) begin
         if ((control_m[c] & flag) == 8'h00)
            status_m[c] |= fm_ctsu_pkg::FLAG_IRQ | flag;
         return span;
      end
      return left - count_type'(1);
   endfunction

   // Apply one request word to the shadow state and return the response it gives
   function automatic rsp_word_type apply_timer_word(input logic [2:0] func, input logic chip,
                                                     input logic [7:0] data);
      rsp_word_type res;
      int           c;
      int           k;
      res = '0;
      c   = int'(chip);
      if (func == fm_ctsu_pkg::FUNC_TICK) begin
         for (k = 0; k < fm_ctsu_pkg::CHIPS; k++) begin
            if (fast_run_m[k])
               fast_left_m[k] = fast_count_type'(run_down(k, count_type'(fast_left_m[k]),
                                                          count_type'({fast_reload_m[k], 2'b00}),
                                                          fm_ctsu_pkg::FLAG_FAST));
            if (slow_run_m[k])
               slow_left_m[k] = run_down(k, slow_left_m[k], {slow_reload_m[k], 4'b0000},
                                         fm_ctsu_pkg::FLAG_SLOW);
         end
      end else if (c < fm_ctsu_pkg::CHIPS) begin
         case (func)
            fm_ctsu_pkg::FUNC_ADDR_WR: latch_m[c] = data;
            fm_ctsu_pkg::FUNC_STATUS_RD: begin
               res.read_data = status_m[c] & ~(control_m[c] & fm_ctsu_pkg::FLAG_MASKS);
            end
            fm_ctsu_pkg::FUNC_DATA_WR: begin
               case (latch_m[c])
                  fm_ctsu_pkg::REG_FAST_RELOAD: begin
                     fast_reload_m[c] = fm_ctsu_pkg::RELOAD_FULL - {1'b0, data};
                  end
                  fm_ctsu_pkg::REG_SLOW_RELOAD: begin
                     slow_reload_m[c] = fm_ctsu_pkg::RELOAD_FULL - {1'b0, data};
                  end
                  fm_ctsu_pkg::REG_CONTROL: begin
                     if ((data & fm_ctsu_pkg::CTRL_CLEAR_ALL) != 8'h00) begin
                        status_m[c] = '0;
                     end else begin
                        control_m[c] = data;
                        // a running timer keeps its count on a repeated start
                        if ((data & fm_ctsu_pkg::CTRL_FAST_RUN) != 8'h00) begin
                           if (!fast_run_m[c]) begin
                              fast_run_m[c]  = 1'b1;
                              fast_left_m[c] = {fast_reload_m[c], 2'b00};
                           end
                        end else begin
                           fast_run_m[c] = 1'b0;
                        end
                        if ((data & fm_ctsu_pkg::CTRL_SLOW_RUN) != 8'h00) begin
                           if (!slow_run_m[c]) begin
                              slow_run_m[c]  = 1'b1;
                              slow_left_m[c] = {slow_reload_m[c], 4'b0000};
                           end
                        end else begin
                           slow_run_m[c] = 1'b0;
                        end
                        status_m[c] &= ~(data & fm_ctsu_pkg::FLAG_MASKS);
                        // drop the IRQ bit once no timer flag is left
                        if ((status_m[c] & fm_ctsu_pkg::FLAG_TIMERS) == 8'h00)
                           status_m[c] &= fm_ctsu_pkg::FLAG_TIMERS;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
      for (k = 0; k < fm_ctsu_pkg::CHIPS && k < fm_ctsu_pkg::IRQ_W; k++)
         res.irq_lines[k] = status_m[k][7];
      return res;
   endfunction

   // Sender gaps: mostly none or short, a few long, and whole stretches without any
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (words_sent[7:6] == 2'b11) return 0;
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Present one word from a falling edge, hold it until accepted, predict on acceptance
   task automatic send_word(input logic [2:0] func, input logic chip, input logic [7:0] data,
                            input bit typed, input rsp_word_type typed_rsp);
      int           gap;
      rsp_word_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = data;
      req_tuser  = {chip, func};
      do @(posedge clock); while (!req_tready);
      predicted = apply_timer_word(func, chip, data);
      status_words_due.push_back(typed ? typed_rsp : predicted);
      words_sent++;
      @(negedge clock);
   endtask

   // Response side: random stalls, mostly short with the odd long one
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (ready_hold > 0) begin
         ready_hold--;
         rsp_tready <= 1'b0;
      end else if (cycle_no[9:8] == 2'b01 || $urandom_range(0, 3) != 0) begin
         rsp_tready <= 1'b1;
      end else begin
         ready_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end
   end

   // Compare each response word with the oldest expectation
   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      rsp_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_data = rsp_tdata[7:0];
         got.irq_lines = rsp_tdata[9:8];
         if (status_words_due.size() == 0) begin
            flag_fault($sformatf("response word %h with none due", rsp_tdata));
         end else begin
            want = status_words_due.pop_front();
            if (got.read_data !== want.read_data)
               flag_fault($sformatf("read_data %h, expected %h", got.read_data, want.read_data));
            if (got.irq_lines !== want.irq_lines)
               flag_fault($sformatf("irq_lines %b, expected %b", got.irq_lines, want.irq_lines));
         end
      end
   end

   // Watchdog: end the run if neither side moves a word for too long
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("fm_chip_timer_status_unit regression: fail");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int           k;
      int           r;
      int           target;
      logic         chip;
      logic [7:0]   reg_no;
      logic [7:0]   data;
      rsp_word_type typed_rsp;

      for (k = 0; k < fm_ctsu_pkg::CHIPS; k++) begin
         latch_m[k]       = '0;
         status_m[k]      = '0;
         control_m[k]     = '0;
         fast_reload_m[k] = fm_ctsu_pkg::RELOAD_FULL;
         slow_reload_m[k] = fm_ctsu_pkg::RELOAD_FULL;
         fast_run_m[k]    = 1'b0;
         slow_run_m[k]    = 1'b0;
         fast_left_m[k]   = '0;
         slow_left_m[k]   = '0;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed words first
      for (k = 0; k < DIRECTED_ROWS; k++) begin
         typed_rsp.read_data = STEP_TABLE[k].want_rd;
         typed_rsp.irq_lines = STEP_TABLE[k].want_irq;
         send_word(STEP_TABLE[k].func, STEP_TABLE[k].chip, STEP_TABLE[k].data,
                   STEP_TABLE[k].typed, typed_rsp);
      end

      // random part: mostly ticks and well-formed register programming,
      // short reloads so that both timers expire often, plus some noise
      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         r    = $urandom_range(0, 99);
         chip = 1'($urandom_range(0, 1));
         if (r < 50) begin
            repeat ($urandom_range(1, 8))
               send_word(fm_ctsu_pkg::FUNC_TICK, 1'($urandom_range(0, 1)), 8'($urandom),
                         1'b0, '0);
         end else if (r < 72) begin
            r = $urandom_range(0, 9);
            if (r < 3) begin
               reg_no = fm_ctsu_pkg::REG_FAST_RELOAD;
               data   = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                    : 8'hf0 | 8'($urandom_range(0, 15));
            end else if (r < 6) begin
               reg_no = fm_ctsu_pkg::REG_SLOW_RELOAD;
               data   = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                    : 8'hf8 | 8'($urandom_range(0, 7));
            end else begin
               reg_no  = fm_ctsu_pkg::REG_CONTROL;
               data    = 8'($urandom);
               data[7] = ($urandom_range(0, 9) == 0);
               if ($urandom_range(0, 2) != 0) data[6:5] = 2'b00;
               if ($urandom_range(0, 3) != 0) data[1:0] = 2'b11;
            end
            send_word(fm_ctsu_pkg::FUNC_ADDR_WR, chip, reg_no, 1'b0, '0);
            send_word(fm_ctsu_pkg::FUNC_DATA_WR, chip, data, 1'b0, '0);
         end else if (r < 85) begin
            send_word(fm_ctsu_pkg::FUNC_STATUS_RD, chip, 8'($urandom), 1'b0, '0);
         end else begin
            send_word(3'($urandom_range(0, 7)), chip, 8'($urandom), 1'b0, '0);
         end
      end
      req_tvalid = 1'b0;

      // drain: wait for every response, then a few more clocks for strays
      while (status_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("fm_chip_timer_status_unit regression: pass");
      else
         $display("fm_chip_timer_status_unit regression: fail");
      $finish;
   end

endmodule
